### hdl/wavetable_polyphonic_synth_core_assert.svh
`ifndef WAVETABLE_POLYPHONIC_SYNTH_CORE_ASSERT_SVH
`define WAVETABLE_POLYPHONIC_SYNTH_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define WPS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the cycle after the antecedent
`define WPS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/wps_pkg.sv
package wps_pkg;

	localparam int TABLE_SIZE = 1000;
	localparam int QTR        = TABLE_SIZE / 4;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int PHASE_W    = IDX_W + 16;
	localparam int JW         = $clog2(QTR + 1);
	localparam int MAG_W      = 15;
	localparam int VOL_W      = 4;
	localparam int KEY_W      = 7;
	localparam int VEL_W      = 7;
	localparam int STEP_W     = 24;
	localparam int CMD_W      = 2;
	localparam int DAC_W      = 12;
	localparam int PROD_W     = MAG_W + VOL_W;
	// the sample only keeps bits 27..16 of the mix, so the sum wraps at 28 bits
	localparam int ACC_W      = DAC_W + 16;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ON   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_OFF  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	localparam logic [PHASE_W:0] SPAN       = (PHASE_W + 1)'(TABLE_SIZE * 65536);
	localparam logic [DAC_W-1:0] DAC_OFFSET = DAC_W'(2048);

	localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;
	localparam logic [63:0] TS64        = 64'(TABLE_SIZE);

	typedef struct packed {
		logic [CMD_W-1:0]  op;
		logic [KEY_W-1:0]  key;
		logic [VOL_W-1:0]  vol;
		logic [STEP_W-1:0] step;
	} qent_t;

	typedef logic [QTR:0][MAG_W-1:0] mag_tab_t;

	// q62 product, floor
	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
		al  = {32'd0, a[31:0]};
		ah  = {32'd0, a[63:32]};
		bl  = {32'd0, b[31:0]};
		bh  = {32'd0, b[63:32]};
		ll  = al * bl;
		lh  = al * bh;
		hl  = ah * bl;
		hh  = ah * bh;
		mid = {32'd0, ll[63:32]} + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
		lo  = {mid[31:0], ll[31:0]};
		hi  = hh + {32'd0, lh[63:32]} + {32'd0, hl[63:32]} + {32'd0, mid[63:32]};
		return {hi[61:0], lo[63:62]};
	endfunction

	// floor(32767 * sin(pi/2 * k / TABLE_SIZE)) by taylor series in q62
	function automatic logic [MAG_W-1:0] sine_mag(input logic [63:0] k);
		logic [63:0] x, x2, term, pos, neg, s, r;
		if (k == 64'd0)
			return '0;
		if (k >= TS64)
			return MAG_W'(32767);
		x    = (PI_HALF_Q62 / TS64) * k + ((PI_HALF_Q62 % TS64) * k) / TS64;
		x2   = qmul(x, x);
		term = x;
		pos  = x;
		neg  = 64'd0;
		term = qmul(term, x2) / 64'd6;   neg = neg + term;
		term = qmul(term, x2) / 64'd20;  pos = pos + term;
		term = qmul(term, x2) / 64'd42;  neg = neg + term;
		term = qmul(term, x2) / 64'd72;  pos = pos + term;
		term = qmul(term, x2) / 64'd110; neg = neg + term;
		term = qmul(term, x2) / 64'd156; pos = pos + term;
		term = qmul(term, x2) / 64'd210; neg = neg + term;
		term = qmul(term, x2) / 64'd272; pos = pos + term;
		term = qmul(term, x2) / 64'd342; neg = neg + term;
		term = qmul(term, x2) / 64'd420; pos = pos + term;
		term = qmul(term, x2) / 64'd506; neg = neg + term;
		term = qmul(term, x2) / 64'd600; pos = pos + term;
		term = qmul(term, x2) / 64'd702; neg = neg + term;
		s = pos - neg;
		r = ({20'd0, s[63:20]} * 64'd32767) >> 42;
		return r[MAG_W-1:0];
	endfunction

	// quarter wave: entry j is the magnitude at table index j
	function automatic mag_tab_t build_mag_tab();
		mag_tab_t t;
		for (int j = 0; j <= QTR; j++)
			t[j] = sine_mag(64'(4 * j));
		return t;
	endfunction

	localparam mag_tab_t MAG_TAB = build_mag_tab();

endpackage

### hdl/wps_fifo.sv
`include "wavetable_polyphonic_synth_core_assert.svh"

module wps_fifo import wps_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t din,
	input  logic  pop,
	output qent_t dout,
	output logic  full,
	output logic  empty
);

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	`WPS_ASSERT_NOW(a_no_overrun, push, !full, "word pushed into a full queue")
	`WPS_ASSERT_NOW(a_no_underrun, pop, !empty, "word popped from an empty queue")
	`WPS_ASSERT_NEXT(a_cnt_push, push && !pop, cnt_q != '0, "queue count lost a push")

endmodule

### hdl/wps_front.sv
module wps_front import wps_pkg::*; (
	input  logic              in_valid,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [KEY_W-1:0]  key,
	input  logic [VEL_W-1:0]  velocity,
	input  logic [STEP_W-1:0] phase_step,
	input  logic              q_full,
	output logic              in_stall,
	output logic              q_push,
	output qent_t             q_data
);

	logic [14:0] vel_x;

	// velocity / 10 as a reciprocal multiply, exact for 7-bit values
	assign vel_x = 15'(velocity) * 15'd205;

	assign in_stall = q_full;
	// unused command words are taken and dropped here
	assign q_push   = in_valid && !q_full && (cmd != CMD_NONE);

	assign q_data.op   = cmd;
	assign q_data.key  = key;
	assign q_data.vol  = vel_x[14:11];
	assign q_data.step = phase_step;

endmodule

### hdl/wps_back.sv
`include "wavetable_polyphonic_synth_core_assert.svh"

module wps_back import wps_pkg::*; #(
	parameter int VOICES = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  qent_t            q_head,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [DAC_W-1:0] dac_sample
);

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam logic [VW-1:0] V_LAST = VW'(VOICES - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]         st_q;
	logic [VW-1:0]      v_q;
	logic [VOICES-1:0]  busy_q;
	logic [KEY_W-1:0]   vkey_q   [VOICES];
	logic [VOL_W-1:0]   vvol_q   [VOICES];
	logic [STEP_W-1:0]  vstep_q  [VOICES];
	logic [PHASE_W-1:0] vphase_q [VOICES];

	logic              free_hit, off_hit;
	logic [VW-1:0]     free_idx, off_idx;
	logic              do_on, do_off, start_tick, scan, emit;
	logic [PHASE_W-1:0] cur_phase;
	logic [PHASE_W:0]  sum_phase, wrap_phase;
	logic [IDX_W:0]    idx_e;
	logic [JW-1:0]     j_c;
	logic              neg_c;

	logic              valid_s1, valid_s2, valid_s3;
	logic              last_s1, last_s2, last_s3;
	logic              neg_s1, neg_s2, neg_s3;
	logic [JW-1:0]     j_s1;
	logic [VOL_W-1:0]  vol_s1, vol_s2;
	logic [MAG_W-1:0]  mag_s2;
	logic [PROD_W-1:0] prod_s3;
	logic [ACC_W-1:0]  term;
	logic [ACC_W-1:0]  acc_q;
	logic              done_q;
	logic              out_valid_q;
	logic [DAC_W-1:0]  dac_q;

	// lowest free voice and lowest active voice holding the key
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		off_hit  = 1'b0;
		off_idx  = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_hit = 1'b1;
				free_idx = VW'(i);
			end
			if (busy_q[i] && (vkey_q[i] == q_head.key)) begin
				off_hit = 1'b1;
				off_idx = VW'(i);
			end
		end
	end

	assign q_pop      = (st_q == ST_IDLE) && !q_empty;
	assign do_on      = q_pop && (q_head.op == CMD_ON) && free_hit;
	assign do_off     = q_pop && (q_head.op == CMD_OFF) && off_hit;
	assign start_tick = q_pop && (q_head.op == CMD_TICK);
	assign scan       = (st_q == ST_SCAN);
	assign emit       = (st_q == ST_DRAIN) && done_q && (!out_valid_q || !out_stall);

	assign cur_phase  = vphase_q[v_q];
	assign sum_phase  = {1'b0, cur_phase} + (PHASE_W + 1)'(vstep_q[v_q]);
	assign wrap_phase = (sum_phase >= SPAN) ? (sum_phase - SPAN) : sum_phase;

	// fold the table index onto the quarter wave
	assign idx_e = {1'b0, cur_phase[PHASE_W-1:16]};
	always_comb begin
		priority if (idx_e < (IDX_W + 1)'(QTR)) begin
			j_c   = JW'(idx_e);
			neg_c = 1'b0;
		end else if (idx_e < (IDX_W + 1)'(2 * QTR)) begin
			j_c   = JW'((IDX_W + 1)'(2 * QTR) - idx_e);
			neg_c = 1'b0;
		end else if (idx_e < (IDX_W + 1)'(3 * QTR)) begin
			j_c   = JW'(idx_e - (IDX_W + 1)'(2 * QTR));
			neg_c = 1'b1;
		end else begin
			j_c   = JW'((IDX_W + 1)'(4 * QTR) - idx_e);
			neg_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			for (int i = 0; i < VOICES; i++)
				vphase_q[i] <= '0;
		end else begin
			if (do_on)
				busy_q[free_idx] <= (q_head.step != '0);
			if (do_off)
				busy_q[off_idx] <= 1'b0;
			if (scan && busy_q[v_q])
				vphase_q[v_q] <= wrap_phase[PHASE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (do_on) begin
			vkey_q[free_idx]  <= q_head.key;
			vvol_q[free_idx]  <= q_head.vol;
			vstep_q[free_idx] <= q_head.step;
		end else if (do_off) begin
			vkey_q[off_idx]  <= '0;
			vvol_q[off_idx]  <= '0;
			vstep_q[off_idx] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			v_q         <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			last_s1     <= 1'b0;
			last_s2     <= 1'b0;
			last_s3     <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= scan;
			last_s1  <= scan && (v_q == V_LAST);
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
			valid_s3 <= valid_s2;
			last_s3  <= last_s2;
			if (valid_s3 && last_s3)
				done_q <= 1'b1;
			else if (emit)
				done_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start_tick) begin
						st_q <= ST_SCAN;
						v_q  <= '0;
					end
				end
				ST_SCAN: begin
					v_q <= v_q + 1'b1;
					if (v_q == V_LAST)
						st_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (emit)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// lookup and multiply pipe, one voice a cycle
	always_ff @(posedge clk) begin
		j_s1    <= j_c;
		neg_s1  <= neg_c;
		vol_s1  <= busy_q[v_q] ? vvol_q[v_q] : '0;
		mag_s2  <= MAG_TAB[j_s1];
		neg_s2  <= neg_s1;
		vol_s2  <= vol_s1;
		prod_s3 <= PROD_W'(mag_s2) * PROD_W'(vol_s2);
		neg_s3  <= neg_s2;
	end

	assign term = ACC_W'({prod_s3, 4'b0000});

	always_ff @(posedge clk) begin
		if (start_tick)
			acc_q <= '0;
		else if (valid_s3)
			acc_q <= neg_s3 ? (acc_q - term) : (acc_q + term);
		if (emit)
			dac_q <= acc_q[ACC_W-1:16] + DAC_OFFSET;
	end

	assign out_valid  = out_valid_q;
	assign dac_sample = dac_q;

	`WPS_ASSERT_NOW(a_pipe_empty_idle, st_q == ST_IDLE, !(valid_s1 || valid_s2 || valid_s3), "voice pipe busy while idle")
	`WPS_ASSERT_NEXT(a_done_after_last, valid_s3 && last_s3, done_q, "mix not flagged done after last voice")
	`WPS_ASSERT_NOW(a_voice_range, st_q == ST_SCAN, v_q <= V_LAST, "voice counter past last voice")

endmodule

### hdl/wavetable_polyphonic_synth_core.sv
// a tick goes through the sweep, s1 to s3, acc_q, done_q and dac_q to the output
// the mix sweeps the voices one a cycle through the single sine lookup and multiplier,
// so a tick holds the back end until its sample is out; note on and off stay in idle
// the four-word queue takes input until full while the back end is busy or output stalls
// asynchronous reset: all voices free with zero phase, queue empty, no clearing pass
module wavetable_polyphonic_synth_core import wps_pkg::*; #(
	parameter int VOICES = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [KEY_W-1:0]  key,
	input  logic [VEL_W-1:0]  velocity,
	input  logic [STEP_W-1:0] phase_step,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DAC_W-1:0]  dac_sample
);

	logic  q_push, q_pop, q_full, q_empty;
	qent_t q_din, q_head;

	wps_front u_front (
		.in_valid   (in_valid),
		.cmd        (cmd),
		.key        (key),
		.velocity   (velocity),
		.phase_step (phase_step),
		.q_full     (q_full),
		.in_stall   (in_stall),
		.q_push     (q_push),
		.q_data     (q_din)
	);

	wps_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	wps_back #(
		.VOICES (VOICES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.dac_sample (dac_sample)
	);

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import wps_pkg::*;

	localparam int NVOICE = 15;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	// predicts the mixed dac sample of every tick and holds the samples still due
	class synth_scoreboard;
		logic [KEY_W-1:0]  vkey [NVOICE];
		logic [STEP_W-1:0] vstep [NVOICE];
		logic [VOL_W-1:0]  vvol [NVOICE];
		logic [31:0]       vphase [NVOICE];
		int                sine [TABLE_SIZE];
		logic [DAC_W-1:0]  samples_due [$];
		int                errors;

		function new();
			logic [63:0] u, q, rr, k;
			int m;
			errors = 0;
			for (int v = 0; v < NVOICE; v++) begin
				vkey[v] = '0;
				vstep[v] = '0;
				vvol[v] = '0;
				vphase[v] = '0;
			end
			// full wave folded from the first quarter
			for (int i = 0; i < TABLE_SIZE; i++) begin
				u = 64'(4 * i);
				q = u / 64'(TABLE_SIZE);
				rr = u % 64'(TABLE_SIZE);
				k = q[0] ? 64'(TABLE_SIZE) - rr : rr;
				m = quarter_mag(k);
				sine[i] = (q >= 2) ? -m : m;
			end
		endfunction

		function logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			return p[125:62];
		endfunction

		// floor(32767 * sin(pi/2 * k / TABLE_SIZE)) by a q62 taylor series
		function int quarter_mag(logic [63:0] k);
			logic [63:0] n, x, x2, term, pos, neg, s, d, r;
			n = 64'(TABLE_SIZE);
			if (k == 64'd0)
				return 0;
			if (k >= n)
				return 32767;
			x = (HALF_PI_Q62 / n) * k + ((HALF_PI_Q62 % n) * k) / n;
			x2 = q62_mul(x, x);
			term = x;
			pos = x;
			neg = 64'd0;
			for (d = 64'd2; d <= 64'd26; d = d + 64'd2) begin
				term = q62_mul(term, x2) / (d * (d + 64'd1));
				if (d[1])
					neg = neg + term;
				else
					pos = pos + term;
			end
			s = pos - neg;
			r = (s >> 20) * 64'd32767;
			return int'(r >> 42);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function int pending();
			return samples_due.size();
		endfunction

		// key of a random sounding voice, or -1 when all are free
		function int sounding_key();
			int keys [$];
			for (int v = 0; v < NVOICE; v++)
				if (vstep[v] != '0)
					keys.push_back(int'(vkey[v]));
			if (keys.size() == 0)
				return -1;
			return keys[$urandom_range(0, keys.size() - 1)];
		endfunction

		function void note_word(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
				logic [VEL_W-1:0] vel, logic [STEP_W-1:0] st);
			longint acc, mix;
			int idx;
			logic [31:0] span;
			span = 32'(TABLE_SIZE) << 16;
			case (c)
				CMD_ON: begin
					for (int v = 0; v < NVOICE; v++) begin
						if (vstep[v] == '0) begin
							vstep[v] = st;
							vkey[v] = k;
							vvol[v] = VOL_W'(vel / 10);
							break;
						end
					end
				end
				CMD_OFF: begin
					for (int v = 0; v < NVOICE; v++) begin
						if (vstep[v] != '0 && vkey[v] == k) begin
							vstep[v] = '0;
							vkey[v] = '0;
							vvol[v] = '0;
							break;
						end
					end
				end
				CMD_TICK: begin
					acc = 0;
					for (int v = 0; v < NVOICE; v++) begin
						if (vstep[v] != '0) begin
							idx = int'(vphase[v] >> 16);
							if (idx >= TABLE_SIZE)
								idx = 0;
							acc += longint'(sine[idx]) * longint'(vvol[v]) * 16;
							vphase[v] = vphase[v] + 32'(vstep[v]);
							if (vphase[v] >= span)
								vphase[v] = vphase[v] - span;
							if (vphase[v] >= span)
								vphase[v] = vphase[v] % span;
						end
					end
					mix = (acc >>> 16) + 2048;
					samples_due.push_back(DAC_W'(mix));
				end
				default: ;
			endcase
		endfunction

		task check_sample(logic [DAC_W-1:0] got);
			logic [DAC_W-1:0] want;
			if (samples_due.size() == 0) begin
				report($sformatf("sample %0d with none due", got));
			end else begin
				want = samples_due.pop_front();
				if (got !== want)
					report($sformatf("dac_sample %0d, want %0d", got, want));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [CMD_W-1:0]  cmd;
	logic [KEY_W-1:0]  key;
	logic [VEL_W-1:0]  velocity;
	logic [STEP_W-1:0] phase_step;
	logic              out_valid;
	logic              out_stall;
	logic [DAC_W-1:0]  dac_sample;

	synth_scoreboard sb;
	bit in_quiet;
	int idle_cycles;

	wavetable_polyphonic_synth_core #(.VOICES(NVOICE)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.key        (key),
		.velocity   (velocity),
		.phase_step (phase_step),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.dac_sample (dac_sample)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task send_word(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
			logic [VEL_W-1:0] vel, logic [STEP_W-1:0] st);
		int gap;
		gap = in_quiet ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		key <= k;
		velocity <= vel;
		phase_step <= st;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(c, k, vel, st);
	endtask

	task send_random_word(int on_pct, int off_pct);
		logic [CMD_W-1:0] c;
		logic [KEY_W-1:0] k;
		logic [STEP_W-1:0] st;
		int r, sk;
		r = $urandom_range(0, 99);
		k = KEY_W'($urandom);
		st = STEP_W'($urandom);
		if (r < 5) begin
			c = CMD_NONE;
		end else if (r < 5 + on_pct) begin
			c = CMD_ON;
			r = $urandom_range(0, 19);
			if (r == 0)
				st = '0;
			else if (r > 3)
				st = STEP_W'($urandom_range(1, 24'h040000));
		end else if (r < 5 + on_pct + off_pct) begin
			c = CMD_OFF;
			sk = sb.sounding_key();
			if (sk >= 0 && $urandom_range(0, 4) != 0)
				k = KEY_W'(sk);
		end else begin
			c = CMD_TICK;
		end
		send_word(c, k, VEL_W'($urandom), st);
	endtask

	initial begin
		int on_pct, off_pct;
		sb = new();
		in_quiet = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_TICK;
		key <= '0;
		velocity <= '0;
		phase_step <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// silence, then the unused command
		send_word(CMD_TICK, '0, '0, '0);
		send_word(CMD_NONE, '1, '1, '1);
		// zero step leaves the voice free
		send_word(CMD_ON, '0, '0, '0);
		send_word(CMD_TICK, '1, '1, '1);
		send_word(CMD_ON, '1, '1, '1);
		send_word(CMD_TICK, '0, '0, '0);
		send_word(CMD_TICK, '0, '0, '0);
		send_word(CMD_ON, 7'd5, 7'd9, 24'h010000);
		// no voice holds this key
		send_word(CMD_OFF, 7'd99, '0, '0);
		// voice 0 is freed and reused with its old phase
		send_word(CMD_OFF, '1, '0, '0);
		send_word(CMD_ON, 7'd64, '1, 24'h00A3D7);
		send_word(CMD_TICK, '0, '0, '0);
		// fill the pool, the last note on finds no free voice
		for (int i = 0; i < 14; i++)
			send_word(CMD_ON, KEY_W'(10 + i), VEL_W'(9 * i),
				STEP_W'($urandom_range(1, 24'h0FFFFF)));
		send_word(CMD_TICK, '0, '0, '0);

		for (int i = 0; i < 1600; i++) begin
			if (i % 200 == 0) begin
				on_pct = $urandom_range(15, 40);
				off_pct = $urandom_range(15, 40);
				in_quiet = ($urandom_range(0, 3) == 0);
			end
			send_random_word(on_pct, off_pct);
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// result side back-pressure, with quiet stretches now and then
	initial begin
		int len;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(100, 300)) @(posedge clk);
			end else begin
				len = idle_len();
				if (len > 0) begin
					out_stall <= 1'b1;
					repeat (len) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_sample(dac_sample);
	end

	// ends the run when no word moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial idle_cycles = 0;

endmodule

### files.f
+incdir+hdl
hdl/wps_pkg.sv
hdl/wps_fifo.sv
hdl/wps_front.sv
hdl/wps_back.sv
hdl/wavetable_polyphonic_synth_core.sv
dv/tb.sv
